// ===== hw/rtl/page_range_bitmap_mark_defines.svh =====
// assertion macros for the page range bitmap block
`ifndef PAGE_RANGE_BITMAP_MARK_DEFINES_SVH
`define PAGE_RANGE_BITMAP_MARK_DEFINES_SVH

`ifndef SYNTHESIS
`define PRBM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prbm check failed");
`define PRBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prbm check failed");
`else
`define PRBM_ASSERT_SAME(lbl, ante, cons)
`define PRBM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/prbm_pkg.sv =====
// shared constants of the page range bitmap block
`default_nettype none

package prbm_pkg;

    localparam int WORD_BITS_DEF  = 64;
    localparam int WORD_COUNT_DEF = 1024;

    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 17;

    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/page_range_bitmap_mark.sv =====
// page range bitmap: set, clear and test of page bits held in a word ram
//
// input channel (i_in_valid / o_in_ready) takes one request: kind selects set
// range, clear range or test one page; start_page and page_count give the run.
// output channel (o_out_valid / i_out_ready) returns one transaction per
// request: bit_value (tested bit, else 0) and range_error (run past map end,
// map left unchanged).
// one request is worked at a time. the page to word/bit split runs through one
// shared reciprocal multiply and correct unit (multiply, estimate and correct
// steps per split), then a read-modify-write walk goes one ram word per cycle
// over a single read and a single write port.
// the next request can be accepted in the same cycle that the result turns valid.
// o_in_ready is low while a request is in flight; a finished result waits in
// the output register while the receiver stalls, and the next request may be
// accepted meanwhile but holds its own result until the register frees.
// after reset a clearing pass writes zero to every word with o_in_ready low.
`default_nettype none

`include "page_range_bitmap_mark_defines.svh"

module page_range_bitmap_mark #(
    parameter int WORD_BITS  = prbm_pkg::WORD_BITS_DEF,
    parameter int WORD_COUNT = prbm_pkg::WORD_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [prbm_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [prbm_pkg::PAGE_W-1:0]  i_start_page,
    input  wire logic [prbm_pkg::COUNT_W-1:0] i_page_count,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_bit_value,
    output logic                              o_range_error
);

    localparam int ADDR_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int END_W   = prbm_pkg::COUNT_W + 1;
    localparam int DIVX_W  = prbm_pkg::COUNT_W;
    localparam int RSHIFT  = 24;
    localparam int RECIP_W = RSHIFT - 2;
    localparam int PROD_W  = RSHIFT + DIVX_W;

    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((2 ** RSHIFT) / WORD_BITS);
    localparam logic [31:0]        TOTAL     = 32'(WORD_COUNT * WORD_BITS);
    localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(WORD_COUNT - 1);
    localparam logic [DIVX_W-1:0]  WB_X      = DIVX_W'(WORD_BITS);
    localparam logic [BIT_W-1:0]   TOP_BIT   = BIT_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ONES    = '1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_QUO   = 4'd4;
    localparam logic [3:0] ST_COR   = 4'd5;
    localparam logic [3:0] ST_TRD   = 4'd6;
    localparam logic [3:0] ST_TWT   = 4'd7;
    localparam logic [3:0] ST_MARK  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0]                  r_state;
    logic [ADDR_W-1:0]           r_clr;
    logic [prbm_pkg::KIND_W-1:0] r_kind;
    logic [prbm_pkg::PAGE_W-1:0] r_first;
    logic [END_W-1:0]            r_end;
    logic                        r_res_bit;
    logic                        r_res_err;
    logic                        r_sel_last;
    logic [DIVX_W-1:0]           r_div_x;
    logic [PROD_W-1:0]           r_prod;
    logic [DIVX_W-1:0]           r_q;
    logic [DIVX_W-1:0]           r_rem;
    logic [ADDR_W-1:0]           r_fw;
    logic [ADDR_W-1:0]           r_lw;
    logic [BIT_W-1:0]            r_fbit;
    logic [BIT_W-1:0]            r_lbit;
    logic [ADDR_W-1:0]           r_cur;
    logic                        r_act;
    logic                        r_pend;
    logic [ADDR_W-1:0]           r_pend_w;
    logic                        r_out_valid;
    logic                        r_out_bit;
    logic                        r_out_err;

    logic                        end_past;
    logic                        first_past;
    logic [DIVX_W-1:0]           q_est;
    logic                        rem_ge;
    logic [DIVX_W-1:0]           q_fix;
    logic [BIT_W-1:0]            rem_fix;
    logic [BIT_W-1:0]            lo_sh;
    logic [BIT_W-1:0]            hi_sh;
    logic [WORD_BITS-1:0]        mark_mask;
    logic [WORD_BITS-1:0]        marked;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [WORD_BITS-1:0]        ram_rdata;

    assign end_past   = 32'(r_end) > TOTAL;
    assign first_past = 32'(r_first) >= TOTAL;

    // reciprocal split: estimate is the quotient or one below it
    assign q_est   = r_prod[PROD_W-1:RSHIFT];
    assign rem_ge  = r_rem >= WB_X;
    assign q_fix   = rem_ge ? r_q + DIVX_W'(1) : r_q;
    assign rem_fix = rem_ge ? BIT_W'(r_rem - WB_X) : BIT_W'(r_rem);

    assign lo_sh     = (r_pend_w == r_fw) ? r_fbit : '0;
    assign hi_sh     = (r_pend_w == r_lw) ? TOP_BIT - r_lbit : '0;
    assign mark_mask = (ONES << lo_sh) & (ONES >> hi_sh);
    assign marked    = (r_kind == prbm_pkg::KIND_SET) ? (ram_rdata | mark_mask)
                                                      : (ram_rdata & ~mark_mask);

    assign ram_we    = (r_state == ST_CLEAR) || ((r_state == ST_MARK) && r_pend);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_pend_w;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : marked;
    assign ram_re    = (r_state == ST_TRD) || ((r_state == ST_MARK) && r_act);
    assign ram_raddr = (r_state == ST_TRD) ? r_fw : r_cur;

    prbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_act       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == LAST_WORD) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_kind    <= i_kind;
                        r_first   <= i_start_page;
                        r_end     <= END_W'(i_start_page) + END_W'(i_page_count);
                        r_res_bit <= 1'b0;
                        r_res_err <= 1'b0;
                        r_state   <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_sel_last <= 1'b0;
                    r_div_x    <= DIVX_W'(r_first);
                    case (r_kind)
                        prbm_pkg::KIND_SET, prbm_pkg::KIND_CLEAR: begin
                            if (end_past) begin
                                r_res_err <= 1'b1;
                                r_state   <= ST_FIN;
                            end else if (r_end == END_W'(r_first)) begin
                                r_state <= ST_FIN;
                            end else begin
                                r_state <= ST_MUL;
                            end
                        end
                        prbm_pkg::KIND_TEST: begin
                            if (first_past) begin
                                r_res_err <= 1'b1;
                                r_state   <= ST_FIN;
                            end else begin
                                r_state <= ST_MUL;
                            end
                        end
                        default: begin
                            r_state <= ST_FIN;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_div_x) * PROD_W'(RECIP);
                    r_state <= ST_QUO;
                end
                ST_QUO: begin
                    r_q     <= q_est;
                    r_rem   <= r_div_x - DIVX_W'(q_est * WB_X);
                    r_state <= ST_COR;
                end
                ST_COR: begin
                    if (!r_sel_last) begin
                        r_fw   <= q_fix[ADDR_W-1:0];
                        r_fbit <= rem_fix;
                        if (r_kind == prbm_pkg::KIND_TEST) begin
                            r_state <= ST_TRD;
                        end else begin
                            r_sel_last <= 1'b1;
                            r_div_x    <= DIVX_W'(r_end - END_W'(1));
                            r_state    <= ST_MUL;
                        end
                    end else begin
                        r_lw    <= q_fix[ADDR_W-1:0];
                        r_lbit  <= rem_fix;
                        r_cur   <= r_fw;
                        r_act   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= ST_MARK;
                    end
                end
                ST_TRD: begin
                    r_state <= ST_TWT;
                end
                ST_TWT: begin
                    r_res_bit <= ram_rdata[r_fbit];
                    r_state   <= ST_FIN;
                end
                ST_MARK: begin
                    if (r_act) begin
                        r_cur    <= r_cur + ADDR_W'(1);
                        r_act    <= (r_cur != r_lw);
                        r_pend_w <= r_cur;
                    end
                    r_pend <= r_act;
                    if (!r_act && !r_pend) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bit   <= r_res_bit;
                        r_out_err   <= r_res_err;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_bit_value   = r_out_bit;
    assign o_range_error = r_out_err;

    `PRBM_ASSERT_SAME(a_err_no_bit, o_out_valid, !(o_bit_value && o_range_error))
    `PRBM_ASSERT_SAME(a_we_only_walk, ram_we, (r_state == ST_MARK) || (r_state == ST_CLEAR))
    `PRBM_ASSERT_SAME(a_walk_in_run, (r_state == ST_MARK) && r_pend,
        (r_pend_w >= r_fw) && (r_pend_w <= r_lw))
    `PRBM_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state == ST_CHK)

endmodule

`default_nettype wire

// ===== hw/rtl/prbm_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module prbm_ram #(
    parameter int WIDTH = prbm_pkg::WORD_BITS_DEF,
    parameter int DEPTH = prbm_pkg::WORD_COUNT_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
